/* rtl/c8ie_pkg.sv */
package c8ie_pkg;

  // Stream payload widths.
  localparam int IN_TDATA_W  = 24;
  localparam int RES_W       = 49;
  localparam int OUT_TDATA_W = 56;

  // Program counter value after reset.
  localparam logic [11:0] START_RESET = 12'h200;

  // Whole-word opcodes.
  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // Register indexes with a special role.
  localparam logic [3:0] REG_0 = 4'h0;
  localparam logic [3:0] REG_F = 4'hF;

  // Top opcode nibble.
  localparam logic [3:0] K_SYS     = 4'h0;
  localparam logic [3:0] K_JP      = 4'h1;
  localparam logic [3:0] K_CALL    = 4'h2;
  localparam logic [3:0] K_SE_IMM  = 4'h3;
  localparam logic [3:0] K_SNE_IMM = 4'h4;
  localparam logic [3:0] K_SE_REG  = 4'h5;
  localparam logic [3:0] K_LD_IMM  = 4'h6;
  localparam logic [3:0] K_ADD_IMM = 4'h7;
  localparam logic [3:0] K_ALU     = 4'h8;
  localparam logic [3:0] K_SNE_REG = 4'h9;
  localparam logic [3:0] K_LD_I    = 4'hA;
  localparam logic [3:0] K_JP_V0   = 4'hB;
  localparam logic [3:0] K_DRW     = 4'hD;
  localparam logic [3:0] K_MISC    = 4'hF;

  // ALU function in the low nibble of 8xyN.
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // Low byte of Fxkk.
  localparam logic [7:0] FX_LD_VX_DT = 8'h07;
  localparam logic [7:0] FX_LD_KEY   = 8'h0A;
  localparam logic [7:0] FX_LD_DT    = 8'h15;
  localparam logic [7:0] FX_LD_ST    = 8'h18;
  localparam logic [7:0] FX_ADD_I    = 8'h1E;

  // One result beat; the first member sits in the highest bits.
  typedef struct packed {
    logic        end_reached;
    logic        stack_error;
    logic        unsupported;
    logic [11:0] sprite_address;
    logic [3:0]  draw_rows;
    logic [7:0]  draw_y;
    logic [7:0]  draw_x;
    logic        draw_request;
    logic        clear_screen;
    logic [11:0] next_pc;
  } res_t;

  // State updates requested by the execute logic.
  typedef struct packed {
    logic        vx_we;
    logic [3:0]  vx_addr;
    logic [7:0]  vx_data;
    logic        vf_we;
    logic        vf_data;
    logic        i_we;
    logic [11:0] i_data;
    logic        delay_we;
    logic        sound_we;
    logic [7:0]  timer_data;
  } wb_t;

  // Return stack requests and status.
  typedef struct packed {
    logic        push;
    logic        pop;
    logic [11:0] push_addr;
  } stk_ctl_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    logic [11:0] top;
  } stk_sts_t;

endpackage

/* rtl/c8ie_ram.sv */
module c8ie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                      rdata_a,
  output logic [WIDTH-1:0]                      rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports; a read in a write cycle returns the old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/c8ie_stack.sv */
module c8ie_stack import c8ie_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  stk_ctl_t ctl,
  output stk_sts_t sts
);

  localparam int LVLW = $clog2(STACK_DEPTH + 1);
  localparam int IDXW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [11:0]     entries [STACK_DEPTH];
  logic [LVLW-1:0] level;
  logic [LVLW-1:0] level_dec;

  assign level_dec = level - LVLW'(1);

  // Fill level; the execute logic only pushes when not full and pops when not empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (ctl.push) begin
      level <= level + LVLW'(1);
    end else if (ctl.pop) begin
      level <= level_dec;
    end
  end

  // Entries hold no reset value; a pop only reads what a push wrote.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[level[IDXW-1:0]] <= ctl.push_addr;
    end
  end

  assign sts.empty = (level == '0);
  assign sts.full  = (level >= LVLW'(STACK_DEPTH));
  assign sts.top   = entries[level_dec[IDXW-1:0]];

endmodule

/* rtl/c8ie_exec.sv */
module c8ie_exec import c8ie_pkg::*; (
  input  logic [15:0] opcode,
  input  logic [3:0]  key_value,
  input  logic [7:0]  vx,
  input  logic [7:0]  vy,
  input  logic [7:0]  v0,
  input  logic [11:0] i_reg,
  input  logic [11:0] pc,
  input  logic [7:0]  delay_value,
  input  stk_sts_t    stk,
  output stk_ctl_t    stk_ctl,
  output wb_t         wb,
  output res_t        res
);

  logic [3:0]  kind;
  logic [3:0]  x;
  logic [3:0]  n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [12:0] pc2;
  logic [12:0] pc4;
  logic [12:0] next;
  logic [8:0]  sum9;

  assign kind = opcode[15:12];
  assign x    = opcode[11:8];
  assign n    = opcode[3:0];
  assign kk   = opcode[7:0];
  assign nnn  = opcode[11:0];
  assign pc2  = {1'b0, pc} + 13'd2;
  assign pc4  = {1'b0, pc} + 13'd4;
  assign sum9 = {1'b0, vx} + {1'b0, vy};

  // Decode and execute one opcode.
  always_comb begin
    next              = pc2;
    wb                = '0;
    wb.vx_addr        = x;
    wb.timer_data     = vx;
    stk_ctl           = '0;
    stk_ctl.push_addr = pc2[11:0];
    res               = '0;

    if (opcode == OP_CLS) begin
      res.clear_screen = 1'b1;
    end else if (opcode == OP_RET) begin
      if (stk.empty) begin
        res.stack_error = 1'b1;
      end else begin
        stk_ctl.pop = 1'b1;
        next        = {1'b0, stk.top};
      end
    end else begin
      case (kind)
        K_SYS: res.unsupported = 1'b1;
        K_JP: next = {1'b0, nnn};
        K_CALL: begin
          // A full stack drops the push but still jumps.
          if (stk.full) begin
            res.stack_error = 1'b1;
          end else begin
            stk_ctl.push = 1'b1;
          end
          next = {1'b0, nnn};
        end
        K_SE_IMM: if (vx == kk) next = pc4;
        K_SNE_IMM: if (vx != kk) next = pc4;
        K_SE_REG: if (vx == vy) next = pc4;
        K_SNE_REG: if (vx != vy) next = pc4;
        K_LD_IMM: begin
          wb.vx_we   = 1'b1;
          wb.vx_data = kk;
        end
        K_ADD_IMM: begin
          wb.vx_we   = 1'b1;
          wb.vx_data = vx + kk;
        end
        K_ALU: begin
          wb.vx_we = 1'b1;
          case (n)
            ALU_MOV: wb.vx_data = vy;
            ALU_OR:  wb.vx_data = vx | vy;
            ALU_AND: wb.vx_data = vx & vy;
            ALU_XOR: wb.vx_data = vx ^ vy;
            ALU_ADD: begin
              wb.vx_data = sum9[7:0];
              wb.vf_we   = 1'b1;
              wb.vf_data = sum9[8];
            end
            ALU_SUB: begin
              wb.vx_data = vx - vy;
              wb.vf_we   = 1'b1;
              wb.vf_data = (vx >= vy);
            end
            ALU_SHR: begin
              wb.vx_data = {1'b0, vy[7:1]};
              wb.vf_we   = 1'b1;
              wb.vf_data = vy[0];
            end
            ALU_SUBN: begin
              wb.vx_data = vy - vx;
              wb.vf_we   = 1'b1;
              wb.vf_data = (vy >= vx);
            end
            ALU_SHL: begin
              wb.vx_data = {vy[6:0], 1'b0};
              wb.vf_we   = 1'b1;
              wb.vf_data = vy[7];
            end
            default: begin
              wb.vx_we        = 1'b0;
              res.unsupported = 1'b1;
            end
          endcase
        end
        K_LD_I: begin
          wb.i_we   = 1'b1;
          wb.i_data = nnn;
        end
        K_JP_V0: next = {1'b0, nnn} + {5'b0, v0};
        K_DRW: begin
          res.draw_request   = 1'b1;
          res.draw_x         = vx;
          res.draw_y         = vy;
          res.draw_rows      = n;
          res.sprite_address = i_reg;
        end
        K_MISC: begin
          case (kk)
            FX_LD_VX_DT: begin
              wb.vx_we   = 1'b1;
              wb.vx_data = delay_value;
            end
            FX_LD_KEY: begin
              wb.vx_we   = 1'b1;
              wb.vx_data = {4'b0, key_value};
            end
            FX_LD_DT: wb.delay_we = 1'b1;
            FX_LD_ST: wb.sound_we = 1'b1;
            FX_ADD_I: begin
              wb.i_we   = 1'b1;
              wb.i_data = i_reg + {4'b0, vx};
            end
            default: res.unsupported = 1'b1;
          endcase
        end
        default: res.unsupported = 1'b1;
      endcase
    end

    res.next_pc     = next[11:0];
    res.end_reached = next[12];
  end

endmodule

/* rtl/chip8_instruction_execute.sv */
// CHIP-8 instruction executor.
// The input stream carries one beat per fetched instruction: the opcode and the
// current keypad code. Each beat gives exactly one result beat with the next PC,
// clear and draw requests and the error flags. The start address register is
// written through cfg_wr_en/cfg_wr_data and also loads the PC at once; write it
// only while no instruction is in flight.
// An accepted beat is executed from the input register and its result is
// registered in the result register that drives m_tvalid. Throughput: one
// instruction per cycle while the receiver does not stall. The V register file
// is a two-read RAM read when the beat is accepted; a write by the instruction
// ahead is forwarded. Reset clears V0..VE (through valid bits), VF, I, the
// stack level, timers and pipeline, and sets PC and start address to 0x200.
// When the receiver stalls, the result stays on m_tdata and one more beat may
// wait in the input register; s_tready drops only when both are full.
module chip8_instruction_execute import c8ie_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // opcode[15:0], key_value[19:16], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // next_pc[11:0], clear_screen[12], draw_request[13], draw_x[21:14],
  // draw_y[29:22], draw_rows[33:30], sprite_address[45:34], unsupported[46],
  // stack_error[47], end_reached[48], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_wr_en,
  input  logic [11:0]            cfg_wr_data
);

  // Input register.
  logic        s1_valid;
  logic [15:0] s1_op;
  logic [3:0]  s1_key;

  // Architectural state outside the RAM.
  logic [11:0] start_address;
  logic [11:0] pc;
  logic [11:0] i_reg;
  logic [7:0]  delay_value;
  logic [7:0]  sound_value;
  logic [7:0]  vf;
  logic [7:0]  v0;
  logic [15:0] vld;

  // RAM read capture and forwarding.
  logic [7:0]  rd_x;
  logic [7:0]  rd_y;
  logic        vld_x;
  logic        vld_y;
  logic        fwd_x;
  logic        fwd_y;
  logic [7:0]  fwd_data;

  logic        in_fire;
  logic        fire;
  logic        ram_we;
  logic [3:0]  in_x;
  logic [3:0]  in_y;
  logic [3:0]  s1_x;
  logic [3:0]  s1_y;
  logic [7:0]  vx;
  logic [7:0]  vy;

  stk_ctl_t    stk_ctl;
  stk_ctl_t    stk_ctl_gated;
  stk_sts_t    stk_sts;
  wb_t         wb;
  res_t        res;
  res_t        res_q;
  logic        out_valid;

  assign fire     = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || fire;
  assign in_fire  = s_tvalid && s_tready;
  assign in_x     = s_tdata[11:8];
  assign in_y     = s_tdata[7:4];
  assign s1_x     = s1_op[11:8];
  assign s1_y     = s1_op[7:4];
  assign ram_we   = fire && wb.vx_we && (wb.vx_addr != REG_F);

  // Input beat register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op  <= s_tdata[15:0];
      s1_key <= s_tdata[19:16];
    end
  end

  // V0..VE live in the RAM; VF is kept in flops since it takes a second write.
  c8ie_ram #(
    .WIDTH(8),
    .DEPTH(16)
  ) u_vregs (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wb.vx_addr),
    .wdata   (wb.vx_data),
    .re      (in_fire),
    .raddr_a (in_x),
    .raddr_b (in_y),
    .rdata_a (rd_x),
    .rdata_b (rd_y)
  );

  // Capture valid bits and the write that lands in the same cycle as the read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vld_x    <= vld[in_x];
      vld_y    <= vld[in_y];
      fwd_x    <= ram_we && (wb.vx_addr == in_x);
      fwd_y    <= ram_we && (wb.vx_addr == in_y);
      fwd_data <= wb.vx_data;
    end
  end

  // An entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[wb.vx_addr] <= 1'b1;
    end
  end

  assign vx = (s1_x == REG_F) ? vf : fwd_x ? fwd_data : vld_x ? rd_x : 8'd0;
  assign vy = (s1_y == REG_F) ? vf : fwd_y ? fwd_data : vld_y ? rd_y : 8'd0;

  c8ie_exec u_exec (
    .opcode      (s1_op),
    .key_value   (s1_key),
    .vx          (vx),
    .vy          (vy),
    .v0          (v0),
    .i_reg       (i_reg),
    .pc          (pc),
    .delay_value (delay_value),
    .stk         (stk_sts),
    .stk_ctl     (stk_ctl),
    .wb          (wb),
    .res         (res)
  );

  always_comb begin
    stk_ctl_gated      = stk_ctl;
    stk_ctl_gated.push = stk_ctl.push && fire;
    stk_ctl_gated.pop  = stk_ctl.pop && fire;
  end

  c8ie_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk (clk),
    .rst (rst),
    .ctl (stk_ctl_gated),
    .sts (stk_sts)
  );

  // Start address and program counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= START_RESET;
      pc            <= START_RESET;
    end else if (cfg_wr_en) begin
      start_address <= cfg_wr_data;
      pc            <= cfg_wr_data;
    end else if (fire) begin
      pc <= res.next_pc;
    end
  end

  // Index register and timers.
  always_ff @(posedge clk) begin
    if (rst) begin
      i_reg       <= '0;
      delay_value <= '0;
      sound_value <= '0;
    end else if (fire) begin
      if (wb.i_we) begin
        i_reg <= wb.i_data;
      end
      if (wb.delay_we) begin
        delay_value <= wb.timer_data;
      end
      if (wb.sound_we) begin
        sound_value <= wb.timer_data;
      end
    end
  end

  // VF takes the flag over the ALU result; V0 is mirrored for BNNN.
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= '0;
      v0 <= '0;
    end else if (fire) begin
      if (wb.vf_we) begin
        vf <= {7'b0, wb.vf_data};
      end else if (wb.vx_we && (wb.vx_addr == REG_F)) begin
        vf <= wb.vx_data;
      end
      if (wb.vx_we && (wb.vx_addr == REG_0)) begin
        v0 <= wb.vx_data;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_q};

endmodule

/* rtl/c8ie_checker.sv */
module c8ie_checker import c8ie_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  res_t res;

  assign res = res_t'(m_tdata[RES_W-1:0]);

  // No result beat comes out of reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  // With the result register empty the block always takes a new beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result register is empty");

  // A stalled result beat stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed or dropped");

  // Draw fields are zero unless a draw is requested.
  a_draw_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.draw_request |->
      res.draw_x == 8'd0 && res.draw_y == 8'd0 &&
      res.draw_rows == 4'd0 && res.sprite_address == 12'd0)
    else $error("draw fields set without a draw request");

  // An unsupported opcode raises no other request.
  a_unsup_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.unsupported |->
      !res.stack_error && !res.draw_request && !res.clear_screen)
    else $error("unsupported opcode with another request");

endmodule

bind chip8_instruction_execute c8ie_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
